### src/zzvd_pkg.sv
// Package for the zigzag varint decoder.
// Holds shared constants, codes and payload types; depends on nothing.
package zzvd_pkg;

    // Byte layout of one varint group.
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned GROUP_BITS = 7;
    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned SHIFT_W    = 6;
    localparam int unsigned HALF_W     = 32;

    // Index of the last byte that may still carry a group (tenth byte).
    localparam logic [COUNT_W-1:0] LAST_GROUP = COUNT_W'(9);

    // Output form selected by the mode field.
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ZZ32  = 2'd1;
    localparam logic [1:0] MODE_ZZ64  = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    // One input byte with its side fields.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [1:0]        mode;
        logic              end_of_data;
    } t_in_item;

    // One decoded result.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         status;
    } t_result;

    // Final form of a completed raw value according to the mode.
    function automatic logic [VALUE_W-1:0] finish_value(
        input logic [VALUE_W-1:0] raw,
        input logic [1:0]         mode
    );
        logic [HALF_W-1:0]  lo;
        logic [VALUE_W-1:0] res;
        begin
            lo = raw[HALF_W-1:0];
            case (mode)
                MODE_ZZ32: begin
                    res = {{(VALUE_W-HALF_W){1'b0}},
                           (lo >> 1) ^ {HALF_W{lo[0]}}};
                end
                MODE_ZZ64: begin
                    res = (raw >> 1) ^ {VALUE_W{raw[0]}};
                end
                default: begin
                    res = raw;
                end
            endcase
            return res;
        end
    endfunction

endpackage

### src/zzvd_if.sv
// Valid/ready channel interfaces for the varint decoder.
// Depends on zzvd_pkg for payload widths.
interface zzvd_in_if
    import zzvd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic [1:0]        mode;
    logic              end_of_data;

    modport source (output valid, data_byte, mode, end_of_data, input ready);
    modport sink   (input valid, data_byte, mode, end_of_data, output ready);
endinterface

interface zzvd_out_if
    import zzvd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [1:0]         status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

### src/zzvd_in_stage.sv
// Input register of the varint decoder: captures one byte request.
// Depends on zzvd_pkg.
module zzvd_in_stage
    import zzvd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_taken,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    // The register may load when empty or when its byte leaves this cycle.
    assign o_ready = !r_valid || i_taken;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### src/zzvd_core.sv
// Decode step of the varint decoder: accumulator, group count and result logic.
// Depends on zzvd_pkg.
module zzvd_core
    import zzvd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  logic     i_out_free,
    output logic     o_taken,
    output logic     o_result_valid,
    output t_result  o_result
);

    logic [VALUE_W-1:0] r_acc;
    logic [COUNT_W-1:0] r_cnt;
    logic [VALUE_W-1:0] n_acc;
    logic [COUNT_W-1:0] n_cnt;

    logic [SHIFT_W-1:0] shift;
    logic               cont;
    logic               last;
    logic               has_result;
    logic [VALUE_W-1:0] raw;
    t_result            result;

    // Position of the current group and the value it completes.
    assign shift = SHIFT_W'(r_cnt) * SHIFT_W'(GROUP_BITS);
    assign cont  = i_item.data_byte[BYTE_W-1];
    assign last  = (r_cnt == LAST_GROUP);
    assign raw   = r_acc | ({{(VALUE_W-BYTE_W){1'b0}}, i_item.data_byte} << shift);

    assign has_result = !cont || last || i_item.end_of_data;

    // Result selection; a terminating byte wins over overflow and truncation.
    always_comb begin
        if (!cont) begin
            result.value  = finish_value(raw, i_item.mode);
            result.status = STATUS_OK;
        end else if (last) begin
            result.value  = '0;
            result.status = STATUS_OVERFLOW;
        end else begin
            result.value  = '0;
            result.status = STATUS_TRUNCATED;
        end
    end

    // A byte leaves the input register unless its result would meet a full output.
    assign o_taken        = i_valid && (!has_result || i_out_free);
    assign o_result_valid = o_taken && has_result;
    assign o_result       = result;

    // Next accumulator state: clear after a result, otherwise merge the group.
    always_comb begin
        n_acc = r_acc;
        n_cnt = r_cnt;
        if (o_taken) begin
            if (has_result) begin
                n_acc = '0;
                n_cnt = '0;
            end else begin
                n_acc = r_acc | ({{(VALUE_W-GROUP_BITS){1'b0}},
                                  i_item.data_byte[GROUP_BITS-1:0]} << shift);
                n_cnt = r_cnt + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    // The group count never passes the tenth byte.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LAST_GROUP)
        else $error("group count out of range");

    // Every result clears the value state.
    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> (r_cnt == '0) && (r_acc == '0))
        else $error("state not cleared after result");

    // A continuation byte advances the count by one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_taken && !has_result) |=> (r_cnt == $past(r_cnt) + COUNT_W'(1)))
        else $error("group count did not advance");

    // Error results carry a zero value.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status != STATUS_OK)) |-> (o_result.value == '0))
        else $error("error result with nonzero value");

    // Overflow only comes from the tenth byte.
    a_overflow_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status == STATUS_OVERFLOW)) |-> last)
        else $error("overflow before the tenth byte");
`endif

endmodule

### src/zzvd_out_stage.sv
// Output register of the varint decoder: holds one result until it is taken.
// Depends on zzvd_pkg.
module zzvd_out_stage
    import zzvd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // Free when empty or when the held result is taken this cycle.
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### src/zigzag_varint_decoder_top.sv
// Zigzag varint decoder: one stream byte in, at most one decoded value out.
// The input channel takes one byte request per cycle, while no ending byte
// waits on a full output, with its mode and an end-of-data mark. Bytes come
// least significant 7-bit group first; top bit set continues the value.
// The output channel gives the value (plain, zigzag at 32 bits or zigzag at
// 64 bits, as chosen by the mode on the terminating byte) and a status:
// ok, overflow on a tenth continuing byte, or truncated at end of data.
// Path: an accepted byte is registered in the input register and decoded
// from there; its result is registered in the output register, where the
// receiver takes it. Throughput: one byte per cycle unless an ending byte
// waits on a full output register; the decode step is a 64-bit shift, OR
// and zigzag select between the input register and the output register.
// Reset clears the accumulator, the group count and both valid flags.
// When the receiver stalls, a held result stays in the output register;
// continuation bytes keep flowing, and only a byte that ends a value waits
// in the input register until the output register frees up.
// Depends on zzvd_pkg, zzvd_if and the zzvd stage modules.
module zigzag_varint_decoder_top
    import zzvd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    zzvd_in_if.sink         i_in,
    zzvd_out_if.source      o_out
);

    t_in_item in_item;
    t_in_item s1_item;
    logic     s1_valid;
    logic     taken;
    logic     out_free;
    logic     res_valid;
    t_result  res;
    t_result  out_res;
    logic     in_ready;
    logic     out_valid;

    assign in_item.data_byte   = i_in.data_byte;
    assign in_item.mode        = i_in.mode;
    assign in_item.end_of_data = i_in.end_of_data;

    // Input register.
    zzvd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (in_ready),
        .i_item  (in_item),
        .i_taken (taken),
        .o_valid (s1_valid),
        .o_item  (s1_item)
    );

    assign i_in.ready = in_ready;

    // Decode step with the value state.
    zzvd_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s1_valid),
        .i_item         (s1_item),
        .i_out_free     (out_free),
        .o_taken        (taken),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    // Output register.
    zzvd_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_result (res),
        .o_free   (out_free),
        .o_valid  (out_valid),
        .i_ready  (o_out.ready),
        .o_result (out_res)
    );

    assign o_out.valid  = out_valid;
    assign o_out.value  = out_res.value;
    assign o_out.status = out_res.status;

endmodule

### bench/testbench.sv
// Self-checking bench for the zigzag varint decoder: random byte streams in,
// decoded values checked against a behavioral decoder kept in step with them.
// Depends on zzvd_pkg, the zzvd_if channel interfaces and the decoder top level.
module testbench;
    import zzvd_pkg::*;

    // Mode code that the block treats as plain.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Bench limits: idle cycles before the watchdog trips, and the long
    // receiver hold-off that forces the block to back up.
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned HOLD_AT      = 600;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned RANDOM_ITEMS = 1400;
    localparam int unsigned MAX_REPORTS  = 10;

    // One byte request waiting to be offered, with its lead-in gap.
    typedef struct {
        t_in_item    payload;
        int unsigned gap;
    } t_pending_byte;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    zzvd_in_if  byte_ch ();
    zzvd_out_if result_ch ();

    zigzag_varint_decoder_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (result_ch)
    );

    t_pending_byte byte_queue[$];
    t_result       expected_results[$];

    // Decoder state as the bench tracks it.
    logic [VALUE_W-1:0] gathered_bits = '0;
    logic [COUNT_W-1:0] groups_taken  = '0;

    int unsigned total_items    = 0;
    int unsigned accepted_items = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    int unsigned tx_calm_left   = 0;
    int unsigned tx_wait        = 0;
    bit          tx_loaded      = 1'b0;
    int unsigned rx_calm_left   = 0;
    int unsigned rx_wait        = 0;
    int unsigned hold_left      = 0;
    bit          hold_done      = 1'b0;
    logic        in_fire_q      = 1'b0;
    logic        out_fire_q     = 1'b0;
    t_in_item    taken_byte;
    t_pending_byte next_byte;

    always #5 clk = ~clk;

    // Output form of a completed value for the given mode.
    function automatic logic [VALUE_W-1:0] apply_mode(input logic [VALUE_W-1:0] raw,
                                                       input logic [1:0] mode);
        logic [HALF_W-1:0] low_word;
        low_word = raw[HALF_W-1:0];
        if (mode == MODE_ZZ32) begin
            return {32'd0, (low_word >> 1) ^ (32'd0 - {31'd0, low_word[0]})};
        end
        if (mode == MODE_ZZ64) begin
            return (raw >> 1) ^ (64'd0 - {63'd0, raw[0]});
        end
        return raw;
    endfunction

    // Advance the tracked decoder by one accepted byte and queue any result.
    task automatic decode_byte(input t_in_item item);
        int unsigned shift;
        t_result     res;
        shift = groups_taken * GROUP_BITS;
        if (!item.data_byte[7]) begin
            res.value  = apply_mode(gathered_bits | ({56'd0, item.data_byte} << shift),
                                    item.mode);
            res.status = STATUS_OK;
            expected_results.push_back(res);
            gathered_bits = '0;
            groups_taken  = '0;
        end else if (groups_taken >= LAST_GROUP) begin
            res.value  = '0;
            res.status = STATUS_OVERFLOW;
            expected_results.push_back(res);
            gathered_bits = '0;
            groups_taken  = '0;
        end else if (item.end_of_data) begin
            res.value  = '0;
            res.status = STATUS_TRUNCATED;
            expected_results.push_back(res);
            gathered_bits = '0;
            groups_taken  = '0;
        end else begin
            gathered_bits = gathered_bits | ({57'd0, item.data_byte[6:0]} << shift);
            groups_taken  = groups_taken + 1'b1;
        end
    endtask

    // Compare one delivered result against the oldest expected one.
    task automatic check_result(input logic [VALUE_W-1:0] value, input logic [1:0] status);
        t_result want;
        if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("unexpected result: value %h status %0d", value, status);
            end
        end else begin
            want = expected_results.pop_front();
            if (value !== want.value || status !== want.status) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("result mismatch: expected value %h status %0d, got value %h status %0d",
                             want.value, want.status, value, status);
                end
            end
        end
    endtask

    // Queue one byte request; calm stretches offer bytes back to back.
    task automatic push_byte(input logic [7:0] data, input logic [1:0] mode, input bit eod);
        t_pending_byte pb;
        pb.payload.data_byte   = data;
        pb.payload.mode        = mode;
        pb.payload.end_of_data = eod;
        if (tx_calm_left > 0) begin
            pb.gap = 0;
            tx_calm_left--;
        end else begin
            pb.gap = $urandom_range(0, 9);
        end
        byte_queue.push_back(pb);
        total_items++;
    endtask

    // Sampling at the rising edge: prediction, checking and the watchdog.
    always @(posedge clk) begin
        in_fire_q  <= byte_ch.valid && byte_ch.ready;
        out_fire_q <= result_ch.valid && result_ch.ready;
        if (rst_n) begin
            if (byte_ch.valid && byte_ch.ready) begin
                taken_byte.data_byte   = byte_ch.data_byte;
                taken_byte.mode        = byte_ch.mode;
                taken_byte.end_of_data = byte_ch.end_of_data;
                decode_byte(taken_byte);
                accepted_items++;
            end
            if (result_ch.valid && result_ch.ready) begin
                check_result(result_ch.value, result_ch.status);
            end
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Byte driver: offers queued requests at the falling edge, holding each
    // until it is taken and waiting out the gap drawn for the next one.
    always @(negedge clk) begin
        if (!rst_n) begin
            byte_ch.valid <= 1'b0;
        end else if (!byte_ch.valid || in_fire_q) begin
            if (!tx_loaded && byte_queue.size() != 0) begin
                tx_wait   = byte_queue[0].gap;
                tx_loaded = 1'b1;
            end
            if (tx_loaded && tx_wait > 0) begin
                byte_ch.valid <= 1'b0;
                tx_wait--;
            end else if (tx_loaded) begin
                next_byte = byte_queue.pop_front();
                tx_loaded = 1'b0;
                byte_ch.data_byte   <= next_byte.payload.data_byte;
                byte_ch.mode        <= next_byte.payload.mode;
                byte_ch.end_of_data <= next_byte.payload.end_of_data;
                byte_ch.valid       <= 1'b1;
            end else begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls per result, calm stretches, and one
    // long hold-off while the sender keeps offering bytes.
    always @(negedge clk) begin
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (!hold_done && accepted_items >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (out_fire_q) begin
                if (rx_calm_left == 0 && $urandom_range(0, 24) == 0) begin
                    rx_calm_left = $urandom_range(20, 60);
                end
                if (rx_calm_left > 0) begin
                    rx_wait = 0;
                    rx_calm_left--;
                end else begin
                    rx_wait = $urandom_range(0, 9);
                end
            end
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else if (rx_wait > 0) begin
                result_ch.ready <= 1'b0;
                rx_wait--;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int unsigned kind;
        int unsigned len;
        int unsigned pick;
        logic [1:0]  value_mode;
        logic [1:0]  byte_mode;

        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = '0;
        byte_ch.mode        = MODE_PLAIN;
        byte_ch.end_of_data = 1'b0;
        result_ch.ready     = 1'b0;

        // Directed: single-byte extremes in every mode, end of data on a
        // terminating byte, and the unused mode.
        push_byte(8'h00, MODE_PLAIN, 1'b0);
        push_byte(8'h7f, MODE_UNUSED, 1'b1);
        push_byte(8'h01, MODE_ZZ32, 1'b0);
        push_byte(8'h01, MODE_ZZ64, 1'b0);

        // Ten-byte value whose last byte carries bits that fall off the top,
        // with the mode changing along the way.
        for (int i = 0; i < 9; i++) begin
            push_byte(8'hff, (i % 2 == 0) ? MODE_PLAIN : MODE_ZZ32, 1'b0);
        end
        push_byte(8'h7f, MODE_ZZ64, 1'b0);

        // Tenth continuing byte: overflow wins over the end-of-data mark.
        for (int i = 0; i < 9; i++) begin
            push_byte(8'hff, MODE_PLAIN, 1'b0);
        end
        push_byte(8'hff, MODE_PLAIN, 1'b1);

        // End of data on the first continuation byte.
        push_byte(8'h80, MODE_ZZ32, 1'b1);

        // Random part: mostly well-formed values, some overflows, some
        // truncations and some raw noise.
        while (total_items < RANDOM_ITEMS + 25) begin
            if (tx_calm_left == 0 && $urandom_range(0, 15) == 0) begin
                tx_calm_left = $urandom_range(20, 60);
            end
            kind       = $urandom_range(0, 99);
            value_mode = 2'($urandom_range(0, 3));
            if (kind < 70) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    len = $urandom_range(1, 2);
                end else if (pick < 9) begin
                    len = $urandom_range(3, 5);
                end else begin
                    len = $urandom_range(6, 10);
                end
                for (int i = 1; i < len; i++) begin
                    byte_mode = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3))
                                                            : value_mode;
                    push_byte(8'h80 | 8'($urandom_range(0, 127)), byte_mode, 1'b0);
                end
                push_byte(8'($urandom_range(0, 127)), value_mode,
                          $urandom_range(0, 3) == 0);
            end else if (kind < 80) begin
                for (int i = 1; i < 10; i++) begin
                    push_byte(8'h80 | 8'($urandom_range(0, 127)), value_mode, 1'b0);
                end
                push_byte(8'h80 | 8'($urandom_range(0, 127)), value_mode,
                          $urandom_range(0, 1) == 1);
            end else if (kind < 90) begin
                len = $urandom_range(1, 9);
                for (int i = 1; i < len; i++) begin
                    push_byte(8'h80 | 8'($urandom_range(0, 127)), value_mode, 1'b0);
                end
                push_byte(8'h80 | 8'($urandom_range(0, 127)), value_mode, 1'b1);
            end else begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    push_byte(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                              $urandom_range(0, 3) == 0);
                end
            end
        end
        // Close any value left open by the noise.
        push_byte(8'h05, MODE_PLAIN, 1'b0);

        // Reset, released at a falling edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_items != total_items) @(negedge clk);
        while (expected_results.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (expected_results.size() != 0) begin
            $display("%0d expected results never arrived", expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
